FILE: src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int WW = 64;
	localparam int CW = $clog2(WW + 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic          start;
		logic [WW-1:0] dividend;
		logic [WW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [WW-1:0] quot;
		logic [WW-1:0] rem;
	} div_rsp_t;
endpackage

FILE: src/rau_div.sv
// Iterative restoring signed divider, one quotient bit per cycle, truncating.
module rau_div import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [WW-1:0] rem_q;
	logic [WW-1:0] quo_q;
	logic [WW-1:0] dvs_q;
	logic          nq_q;
	logic          nr_q;
	logic          done_q;
	logic [WW:0]   trial;
	logic [WW:0]   shifted;
	logic [WW-1:0] ua;
	logic [WW-1:0] ub;

	assign ua = req.dividend[WW-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign ub = req.divisor[WW-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign shifted = {rem_q, quo_q[WW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= ua;
			dvs_q <= ub;
			nq_q  <= req.dividend[WW-1] ^ req.divisor[WW-1];
			nr_q  <= req.dividend[WW-1];
		end else if (busy_q) begin
			if (!trial[WW]) begin
				rem_q <= trial[WW-1:0];
				quo_q <= {quo_q[WW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WW-1:0];
				quo_q <= {quo_q[WW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = nq_q ? (~quo_q + 1'b1) : quo_q;
	assign rsp.rem  = nr_q ? (~rem_q + 1'b1) : rem_q;
endmodule

FILE: src/rational_arith_unit_core.sv
// Top level of the rational arithmetic unit: sequencer around a shared divider.
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | op a_num a_den b_num b_den
//  out     | out_valid | out_stall | q_num q_den status is_whole
// Sequence: error items go from MUL1 straight to output; others multiply, run
// Euclid steps and then the two final divides on the shared divider.
// Reset clears the sequencer and output valid; no clearing pass.
// in_stall is high from acceptance until the result is taken.
module rational_arith_unit_core import rau_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic signed [31:0]   a_num,
	input  logic signed [31:0]   a_den,
	input  logic signed [31:0]   b_num,
	input  logic signed [31:0]   b_den,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [63:0]   q_num,
	output logic signed [63:0]   q_den,
	output logic                 status,
	output logic                 is_whole
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MUL1 = 8'b00000010,
		S_MUL2 = 8'b00000100,
		S_GCD  = 8'b00001000,
		S_GWT  = 8'b00010000,
		S_DN   = 8'b00100000,
		S_DD   = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t        state_q;
	op_t           op_q;
	logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic [WW-1:0] p0_q, p1_q, n_q, d_q, x_q, y_q;
	logic [WW-1:0] rn_q, rd_q;
	logic          err_q;
	logic          wt_q;
	div_req_t      dreq;
	div_rsp_t      drsp;
	logic          m1;

	function automatic logic signed [WW-1:0] sx(input logic [31:0] v);
		return WW'($signed(v[OPERAND_WIDTH-1:0]));
	endfunction

	rau_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign m1 = (y_q == '1);

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = x_q;
		dreq.divisor = y_q;
		unique case (state_q)
			S_GCD:   dreq.start = (y_q != '0) && !m1;
			S_DN:    begin
				dreq.dividend = n_q; dreq.divisor = x_q;
				dreq.start = !wt_q && (x_q != '1);
			end
			S_DD:    begin
				dreq.dividend = d_q; dreq.divisor = x_q;
				dreq.start = !wt_q && (x_q != '1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wt_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL1;
				S_MUL1: state_q <= err_q ? S_OUT : S_MUL2;
				S_MUL2: state_q <= S_GCD;
				S_GCD: begin
					if (y_q == '0) state_q <= S_DN;
					else if (!m1) state_q <= S_GWT;
				end
				S_GWT: if (drsp.done) state_q <= S_GCD;
				S_DN: begin
					if (x_q == '1) state_q <= S_DD;
					else if (!wt_q) wt_q <= 1'b1;
					else if (drsp.done) begin
						wt_q    <= 1'b0;
						state_q <= S_DD;
					end
				end
				S_DD: begin
					if (x_q == '1) state_q <= S_OUT;
					else if (!wt_q) wt_q <= 1'b1;
					else if (drsp.done) begin
						wt_q    <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				op_q <= op_t'(op);
				an_q <= a_num[OPERAND_WIDTH-1:0]; ad_q <= a_den[OPERAND_WIDTH-1:0];
				bn_q <= b_num[OPERAND_WIDTH-1:0]; bd_q <= b_den[OPERAND_WIDTH-1:0];
				err_q <= (sx(a_den) == '0) || (sx(b_den) == '0) ||
				         ((op_t'(op) == OP_DIV) && (sx(b_num) == '0));
			end
			S_MUL1: begin
				unique case (op_q)
					OP_MUL:  begin p0_q <= WW'(an_q * bn_q); p1_q <= '0; end
					OP_DIV:  begin p0_q <= WW'(an_q * bd_q); p1_q <= '0; end
					default: begin p0_q <= WW'(an_q * bd_q); p1_q <= WW'(bn_q * ad_q); end
				endcase
				d_q <= (op_q == OP_DIV) ? WW'(ad_q * bn_q) : WW'(ad_q * bd_q);
			end
			S_MUL2: begin
				n_q <= (op_q == OP_SUB) ? p0_q - p1_q : p0_q + p1_q;
				x_q <= (op_q == OP_SUB) ? p0_q - p1_q : p0_q + p1_q;
				y_q <= d_q;
			end
			S_GCD: if (m1) begin
				x_q <= y_q; y_q <= '0;
			end
			S_GWT: if (drsp.done) begin
				x_q <= y_q; y_q <= drsp.rem;
			end
			S_DN: begin
				if (x_q == '1) rn_q <= ~n_q + 1'b1;
				else if (drsp.done && wt_q) rn_q <= drsp.quot;
			end
			S_DD: begin
				if (x_q == '1) rd_q <= ~d_q + 1'b1;
				else if (drsp.done && wt_q) rd_q <= drsp.quot;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign q_num     = err_q ? '0 : rn_q;
	assign q_den     = err_q ? '0 : rd_q;
	assign status    = err_q;
	assign is_whole  = !err_q && (rd_q == WW'(1));

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> (q_num == '0) && (q_den == '0) && !is_whole)
		else $error("error result not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> (state_q == S_GCD || state_q == S_DN || state_q == S_DD))
		else $error("divider started out of sequence");
	a_nz_div: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> (dreq.divisor != '0))
		else $error("divide by zero in divider");
`endif
endmodule

FILE: tb/sv/tb_rational_arith_unit_core.sv
// Self-checking testbench for rational_arith_unit_core: random and directed fraction requests.
module tb_rational_arith_unit_core;
	import rau_pkg::*;

	typedef struct {
		op_t         op;
		logic [31:0] an, ad, bn, bd;
	} frac_req_t;

	typedef struct {
		logic signed [63:0] num, den;
		logic               status, whole;
	} frac_rsp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = 2'd0;
	logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] q_num, q_den;
	logic               status, is_whole;

	frac_req_t pending_reqs[$];
	frac_rsp_t expected_quotients[$];
	int        total_reqs, sent_reqs, got_rsps, err_rsps, fail_cnt, idle_cycles;
	int        in_gap, out_gap, hold_cnt;
	bit        hold_done;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int TAIL = 100;

	rational_arith_unit_core dut (.*);

	initial forever #4 clk = ~clk;

	function automatic longint trem(longint x, longint y);
		return (y == -1) ? 64'sd0 : x % y;
	endfunction

	function automatic longint tdiv(longint x, longint y);
		return (y == -1) ? 64'sd0 - x : x / y;
	endfunction

	function automatic frac_rsp_t reduce_fraction(op_t o, longint an, longint ad,
			longint bn, longint bd);
		frac_rsp_t r;
		longint    n, d, g, y, t;
		if (ad == 0 || bd == 0 || (o == OP_DIV && bn == 0)) begin
			r.num = 0; r.den = 0; r.status = 1'b1; r.whole = 1'b0;
			return r;
		end
		case (o)
			OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
			OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
			OP_MUL: begin n = an * bn; d = ad * bd; end
			default: begin n = an * bd; d = ad * bn; end
		endcase
		g = n;
		y = d;
		while (y != 0) begin
			t = g;
			g = y;
			y = trem(t, y);
		end
		r.num = tdiv(n, g);
		r.den = tdiv(d, g);
		r.status = 1'b0;
		r.whole = (r.den == 1);
		return r;
	endfunction

	function automatic logic [31:0] rand_val(int kind);
		case (kind)
			0: return 32'($signed($urandom_range(0, 2000)) - 1000);
			1: return 32'($signed($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(op_t o, logic [31:0] an, ad, bn, bd);
		frac_req_t q;
		q.op = o; q.an = an; q.ad = ad; q.bn = bn; q.bd = bd;
		pending_reqs.push_back(q);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic      nv;
		frac_req_t q;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				expected_quotients.push_back(reduce_fraction(op_t'(op), a_num, a_den,
					b_num, b_den));
				sent_reqs++;
			end
			if (!in_valid || !in_stall) begin
				nv = 1'b0;
				if (in_gap > 0)
					in_gap--;
				else if (pending_reqs.size() > 0) begin
					if (pending_reqs.size() > TAIL && $urandom_range(0, 5) == 0)
						in_gap = $urandom_range(1, 7) - 1;
					else begin
						q = pending_reqs.pop_front();
						op <= q.op; a_num <= q.an; a_den <= q.ad;
						b_num <= q.bn; b_den <= q.bd;
						nv = 1'b1;
					end
				end
			end
			in_valid <= nv;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		frac_rsp_t e;
		logic      ns;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
			hold_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_rsps++;
				if (expected_quotients.size() == 0) begin
					$display("%0t: unexpected result q_num=%0d q_den=%0d", $time, q_num, q_den);
					fail_cnt++;
				end else begin
					e = expected_quotients.pop_front();
					if (e.status) err_rsps++;
					if (q_num !== e.num) begin
						$display("%0t: q_num exp %0d got %0d", $time, e.num, q_num);
						fail_cnt++;
					end
					if (q_den !== e.den) begin
						$display("%0t: q_den exp %0d got %0d", $time, e.den, q_den);
						fail_cnt++;
					end
					if (status !== e.status) begin
						$display("%0t: status exp %0b got %0b", $time, e.status, status);
						fail_cnt++;
					end
					if (is_whole !== e.whole) begin
						$display("%0t: is_whole exp %0b got %0b", $time, e.whole, is_whole);
						fail_cnt++;
					end
				end
			end
			ns = 1'b0;
			if (!hold_done && sent_reqs == 300) begin
				hold_done = 1'b1;
				hold_cnt = 2000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				ns = 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				ns = 1'b1;
			end else if (sent_reqs < total_reqs - TAIL && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(1, 7) - 1;
				ns = 1'b1;
			end
			out_stall <= ns;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog timeout", $time);
				$display("tb_rational_arith_unit_core: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int k, kind;
		// directed
		add_req(OP_ADD, 1, 2, 1, 3);
		add_req(OP_SUB, 1, 2, 1, 2);
		add_req(OP_MUL, 3, 1, 1, -6);
		add_req(OP_DIV, 0, -3, 5, 1);
		add_req(OP_ADD, 0, -3, 0, 1);
		add_req(OP_DIV, 7, 3, 0, 5);
		add_req(OP_ADD, 1, 0, 1, 1);
		add_req(OP_MUL, 1, 1, 1, 0);
		add_req(OP_SUB, 0, 0, 0, 0);
		add_req(OP_DIV, 3, 4, 3, 4);
		add_req(OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		add_req(OP_ADD, 32'h80000001, 1, 32'h80000001, 1);
		add_req(OP_SUB, 32'h7fffffff, 1, 32'h80000001, 1);
		add_req(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 1);
		add_req(OP_ADD, 32'h80000000, 1, 32'h80000000, 1);
		add_req(OP_SUB, 32'h80000000, 1, 32'h7fffffff, 32'h80000000);
		add_req(OP_DIV, 32'h80000000, -1, 32'h80000000, 1);
		add_req(OP_MUL, -1, -1, -1, -1);
		add_req(OP_DIV, 5, -1, -1, 1);
		add_req(OP_MUL, 32'h7fffffff, 32'h80000001, 32'h7ffffffe, 3);
		add_req(OP_SUB, 1, -2, 1, 3);
		// random
		for (k = 0; k < 1000; k++) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 6) ? 0 : (kind < 8) ? 1 : 2;
			add_req(op_t'($urandom_range(0, 3)), rand_val(kind), rand_val(kind),
				rand_val(kind), rand_val(kind));
		end
		total_reqs = pending_reqs.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && sent_reqs == total_reqs &&
			expected_quotients.size() == 0);
		repeat (300) @(posedge clk);
		if (expected_quotients.size() != 0) begin
			$display("%0t: %0d results missing", $time, expected_quotients.size());
			fail_cnt++;
		end
		$display("Sent %0d requests over all four ops, %0d results checked (%0d with error).",
			sent_reqs, got_rsps, err_rsps);
		$display("Covered random idling on both sides and one long output hold-off.");
		if (fail_cnt == 0)
			$display("tb_rational_arith_unit_core: PASS");
		else
			$display("tb_rational_arith_unit_core: FAIL");
		$finish;
	end
endmodule
